>>> hw/rtl/afir_pkg.sv
// Shared types, sizes and the coefficient table of the 201-tap audio FIR filter.
// Used by afir_ctrl, afir_datapath, the top level and the checker; depends on nothing.

package afir_pkg;

    localparam int TAP_COUNT   = 201;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int ACC_BITS    = 40;
    localparam int HALF_TAPS   = 101;
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int TAP_BITS    = $clog2(TAP_COUNT);
    localparam int FILL_BITS   = $clog2(TAP_COUNT + 1);
    localparam int CENTRE      = (TAP_COUNT - 1) / 2;
    localparam int COEF_GROW   = (COEF_BITS >= 16) ? COEF_BITS - 16 : 0;
    localparam int COEF_DROP   = (COEF_BITS < 16) ? 16 - COEF_BITS : 1;
    localparam int COEF_HALF   = 1 << (COEF_DROP - 1);

    // Q1.15 taps, outermost first, centre tap last
    localparam int HALF_COEF [HALF_TAPS] = '{
        -8, -5, -15, 1, -15, 2, -6, -2, 9, -4,
        21, 0, 21, 12, 10, 25, -5, 25, -12, 7,
        -8, -25, 0, -51, -1, -51, -19, -21, -41, 21,
        -43, 47, -6, 40, 58, 13, 109, -1, 104, 16,
        33, 50, -65, 55, -127, -4, -113, -111, -42, -196,
        22, -179, 24, -37, -23, 157, -48, 280, 21, 247,
        175, 82, 303, -91, 266, -151, 17, -81, -331, 6,
        -555, -32, -480, -225, -126, -419, 286, -369, 484, 53,
        367, 691, 97, 1137, -16, 989, 206, 159, 579, -978,
        585, -1755, -312, -1629, -2255, -558, -4763, 913, -6896, 1951,
        25035
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_ROUND,
        ST_HOLD
    } afir_state_t;

    typedef struct packed {
        logic capture;
        logic bypass;
        logic load;
        logic run;
        logic round;
        logic load_out;
    } afir_cmd_t;

    typedef struct packed {
        logic enable;
        logic last_tap;
        logic out_free;
    } afir_status_t;

    function automatic logic signed [COEF_BITS-1:0] coef_for_dist(
        input logic [TAP_BITS-1:0] tap_gap
    );
        int q;
        int mag;
        logic signed [COEF_BITS-1:0] c;
        c = '0;
        if (int'(tap_gap) <= HALF_TAPS - 1)
        begin
            q = HALF_COEF[HALF_TAPS - 1 - int'(tap_gap)];
            if (COEF_BITS >= 16)
            begin
                c = COEF_BITS'(q <<< COEF_GROW);
            end
            else
            begin
                mag = (q < 0) ? -q : q;
                mag = (mag + COEF_HALF) >>> COEF_DROP;
                c = COEF_BITS'((q < 0) ? -mag : mag);
            end
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/afir_ctrl.sv
// Sequencing state machine of the FIR filter: accept, load, tap sweep, drain, round, deliver; bypass goes to deliver.
// Depends on afir_pkg for the state type and the command and status structs.

module afir_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  afir_pkg::afir_status_t status,
    output afir_pkg::afir_cmd_t    cmd
);
    import afir_pkg::*;

    afir_state_t state_reg;
    afir_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.enable ? ST_LOAD : ST_HOLD;
                end
            end
            ST_LOAD:   state_next = ST_RUN;
            ST_RUN:
            begin
                if (status.last_tap)
                begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_HOLD;
            ST_HOLD:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                cmd.bypass  = in_valid && !status.enable;
            end
            ST_LOAD:   cmd.load     = 1'b1;
            ST_RUN:    cmd.run      = 1'b1;
            ST_DRAIN1: cmd          = '0;
            ST_DRAIN2: cmd          = '0;
            ST_ROUND:  cmd.round    = 1'b1;
            ST_HOLD:   cmd.load_out = status.out_free;
            default:   cmd          = '0;
        endcase
    end

endmodule

>>> hw/rtl/afir_datapath.sv
// Datapath of the FIR filter: circular delay-line memory, tap counter, MAC pipeline,
// rounding and saturation, enable register and output register. Depends on afir_pkg.

module afir_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_wr_data,
    input  logic signed [afir_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [afir_pkg::SAMPLE_BITS-1:0] sample_out,
    input  afir_pkg::afir_cmd_t                  cmd,
    output afir_pkg::afir_status_t               status
);
    import afir_pkg::*;

    localparam logic signed [ACC_BITS:0] ROUND_BIAS = (ACC_BITS+1)'(1) <<< (COEF_BITS - 2);
    localparam logic signed [ACC_BITS:0] SAT_MAX = (ACC_BITS+1)'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS:0] SAT_MIN = -SAT_MAX - (ACC_BITS+1)'(1);

    logic signed [SAMPLE_BITS-1:0] mem [TAP_COUNT];

    logic                          enable_reg;
    logic [TAP_BITS-1:0]           wr_ptr_reg;
    logic [TAP_BITS-1:0]           rd_ptr_reg;
    logic [TAP_BITS-1:0]           tap_reg;
    logic [FILL_BITS-1:0]          fill_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [COEF_BITS-1:0]   coef_reg;
    logic                          tap_valid_reg;
    logic                          s1_valid_reg;
    logic                          s2_valid_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic signed [SAMPLE_BITS-1:0] result_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;

    logic [TAP_BITS-1:0]           tap_index;
    logic [TAP_BITS-1:0]           tap_dist;
    logic signed [SAMPLE_BITS-1:0] mac_operand;
    logic signed [ACC_BITS:0]      rounded;
    logic signed [ACC_BITS:0]      shifted;
    logic signed [SAMPLE_BITS-1:0] saturated;

    assign tap_index = TAP_BITS'(TAP_COUNT - 1) - tap_reg;
    assign tap_dist  = (tap_index >= TAP_BITS'(CENTRE)) ? tap_index - TAP_BITS'(CENTRE)
                                                        : TAP_BITS'(CENTRE) - tap_index;

    assign mac_operand = tap_valid_reg ? rd_data_reg : '0;

    assign rounded = {acc_reg[ACC_BITS-1], acc_reg} + ROUND_BIAS;
    assign shifted = rounded >>> (COEF_BITS - 1);

    always_comb
    begin
        priority if (shifted > SAT_MAX)
        begin
            saturated = SAT_MAX[SAMPLE_BITS-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            saturated = SAT_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            saturated = shifted[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[wr_ptr_reg] <= sample_reg;
        end
        rd_data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            tap_reg       <= '0;
            fill_reg      <= '0;
            tap_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                enable_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                rd_ptr_reg <= wr_ptr_reg;
                wr_ptr_reg <= (wr_ptr_reg == TAP_BITS'(TAP_COUNT - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
                if (fill_reg != FILL_BITS'(TAP_COUNT))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                tap_reg <= '0;
            end
            else if (cmd.run)
            begin
                rd_ptr_reg <= (rd_ptr_reg == '0) ? TAP_BITS'(TAP_COUNT - 1) : rd_ptr_reg - 1'b1;
                tap_reg    <= tap_reg + 1'b1;
            end
            tap_valid_reg <= FILL_BITS'(tap_reg) < fill_reg;
            s1_valid_reg  <= cmd.run;
            s2_valid_reg  <= s1_valid_reg;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample_in;
        end
        coef_reg <= coef_for_dist(tap_dist);
        prod_reg <= mac_operand * coef_reg;
        if (cmd.load)
        begin
            acc_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_BITS'(prod_reg);
        end
        if (cmd.bypass)
        begin
            result_reg <= sample_in;
        end
        else if (cmd.round)
        begin
            result_reg <= saturated;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= result_reg;
        end
    end

    assign status.enable   = enable_reg;
    assign status.last_tap = (tap_reg == TAP_BITS'(TAP_COUNT - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

endmodule

>>> hw/rtl/audio_fir_filter_201_tap.sv
// Top level of the symmetric 201-tap audio FIR filter: controller plus datapath.
// Depends on afir_pkg, afir_ctrl and afir_datapath.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    sample_in   (signed 16 bit, Q1.15)
//   output    out_valid / out_ready  sample_out  (signed 16 bit, Q1.15)
//   config    cfg_wr_en              cfg_wr_data (filter_enable)
//
// Filtering takes each word from acceptance to the output register through a load state,
// a tap sweep at one tap per cycle through the single delay-line read port and multiplier,
// the drain states ST_DRAIN1 and ST_DRAIN2, a rounding state and a hand-over state; bypass
// goes straight to hand-over. The input reopens in the cycle after hand-over.
// Reset empties the delay line through a fill count; unwritten taps read as zero.
// A new word is accepted while the previous result waits in the output register;
// a stalled output holds the finished result until out_ready.

module audio_fir_filter_201_tap (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic                                    cfg_wr_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [afir_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [afir_pkg::SAMPLE_BITS-1:0] sample_out
);
    import afir_pkg::*;

    afir_cmd_t    cmd;
    afir_status_t status;

    afir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    afir_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample_out  (sample_out),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

>>> hw/rtl/afir_checker.sv
// Port-level checker for the FIR filter top level, attached by bind.
// Depends on afir_pkg for the sample width.

module afir_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    in_valid,
    input logic                                    in_ready,
    input logic                                    out_valid,
    input logic                                    out_ready,
    input logic signed [afir_pkg::SAMPLE_BITS-1:0] sample_out
);
    import afir_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out))
        else $error("stalled output word changed or dropped");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word accepted while one is in progress");

    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("output word appeared without a word in progress");

    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid)
        else $error("input reopened without a result delivered");

endmodule

bind audio_fir_filter_201_tap afir_checker u_afir_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
);

>>> bench/tb_top.sv
// Self-checking bench for audio_fir_filter_201_tap: drives samples with random gaps and stalls,
// predicts each output with its own 201-tap integer filter and compares word by word.
// Depends on afir_pkg and the audio_fir_filter_201_tap RTL.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [afir_pkg::SAMPLE_BITS-1:0] pcm_t;

    localparam int   TAPS           = 201;
    localparam int   CENTRE_TAP     = (TAPS - 1) / 2;
    localparam int   FRAC_BITS      = 15;
    localparam pcm_t PCM_MAX        = pcm_t'(16'sh7fff);
    localparam pcm_t PCM_MIN        = pcm_t'(16'sh8000);
    localparam bit   MODE_FILTER    = 1'b1;
    localparam bit   MODE_BYPASS    = 1'b0;
    localparam int   TARGET_WORDS   = 1650;
    localparam int   IDLE_LIMIT     = 20000;
    localparam int   RX_HOLD_CYCLES = 2500;
    localparam int   SETTLE_CYCLES  = 250;

    localparam int FIR_HALF_COEF [101] = '{
        -8, -5, -15, 1, -15, 2, -6, -2, 9, -4,
        21, 0, 21, 12, 10, 25, -5, 25, -12, 7,
        -8, -25, 0, -51, -1, -51, -19, -21, -41, 21,
        -43, 47, -6, 40, 58, 13, 109, -1, 104, 16,
        33, 50, -65, 55, -127, -4, -113, -111, -42, -196,
        22, -179, 24, -37, -23, 157, -48, 280, 21, 247,
        175, 82, 303, -91, 266, -151, 17, -81, -331, 6,
        -555, -32, -480, -225, -126, -419, 286, -369, 484, 53,
        367, 691, 97, 1137, -16, 989, 206, 159, 579, -978,
        585, -1755, -312, -1629, -2255, -558, -4763, 913, -6896, 1951,
        25035
    };

    class fir_scoreboard;
        bit   filter_on;
        pcm_t history [TAPS];
        int   tap_weight [TAPS];
        pcm_t expected_out [$];
        int   mismatches;
        int   checked;
        int   filtered;
        int   bypassed;
        int   clipped;

        function new();
            int tap_gap;
            filter_on  = MODE_BYPASS;
            mismatches = 0;
            checked    = 0;
            filtered   = 0;
            bypassed   = 0;
            clipped    = 0;
            for (int i = 0; i < TAPS; i++)
            begin
                tap_gap       = (i >= CENTRE_TAP) ? i - CENTRE_TAP : CENTRE_TAP - i;
                tap_weight[i] = FIR_HALF_COEF[CENTRE_TAP - tap_gap];
                history[i]    = '0;
            end
        endfunction

        function void note_sample(pcm_t x);
            longint acc;
            longint rounded;
            if (filter_on == MODE_BYPASS)
            begin
                expected_out.push_back(x);
                bypassed++;
                return;
            end
            for (int i = 0; i < TAPS - 1; i++)
                history[i] = history[i + 1];
            history[TAPS - 1] = x;
            acc = 0;
            for (int i = 0; i < TAPS; i++)
                acc += longint'(history[i]) * longint'(tap_weight[i]);
            rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (rounded > longint'(PCM_MAX))
            begin
                rounded = longint'(PCM_MAX);
                clipped++;
            end
            else if (rounded < longint'(PCM_MIN))
            begin
                rounded = longint'(PCM_MIN);
                clipped++;
            end
            expected_out.push_back(pcm_t'(rounded));
            filtered++;
        endfunction

        function void check_sample(pcm_t y);
            pcm_t want;
            if (expected_out.size() == 0)
            begin
                $error("sample_out: word with no expected value, actual %0d", y);
                mismatches++;
                return;
            end
            want = expected_out.pop_front();
            checked++;
            if (y !== want)
            begin
                $error("sample_out: expected %0d, actual %0d", want, y);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_out.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    logic in_valid;
    logic in_ready;
    pcm_t sample_in;
    logic out_valid;
    logic out_ready;
    pcm_t sample_out;

    fir_scoreboard sb;
    int            words_sent;
    int            enable_writes;
    bit            quiet_traffic;
    bit            rx_hold_request;

    audio_fir_filter_201_tap DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample_out  (sample_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int sender_gap();
        int roll;
        if (quiet_traffic)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    task automatic send_sample(pcm_t v);
        @(negedge clk);
        in_valid  <= 1'b1;
        sample_in <= v;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_sample(v);
        words_sent++;
    endtask

    task automatic idle_sender(int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid  <= 1'b0;
            sample_in <= pcm_t'($urandom);
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic offer(pcm_t v);
        send_sample(v);
        idle_sender(sender_gap());
    endtask

    task automatic drain_results();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_filter(bit on);
        idle_sender(1);
        drain_results();
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.filter_on = on;
        enable_writes++;
    endtask

    task automatic random_segment();
        int   kind;
        int   len;
        pcm_t level;
        kind = $urandom_range(0, 3);
        case (kind)
            0:
            begin
                len = $urandom_range(1, 40);
                repeat (len) offer(pcm_t'($urandom));
            end
            1:
            begin
                case ($urandom_range(0, 2))
                    0:       level = PCM_MAX;
                    1:       level = PCM_MIN;
                    default: level = pcm_t'($urandom);
                endcase
                len = $urandom_range(50, 230);
                repeat (len) offer(level);
            end
            2:
            begin
                len = $urandom_range(20, 120);
                for (int k = 0; k < len; k++)
                    offer(k[0] ? PCM_MAX : PCM_MIN);
            end
            default:
            begin
                len = $urandom_range(10, 60);
                repeat (len)
                begin
                    if ($urandom_range(0, 7) == 0)
                        offer($urandom_range(0, 1) ? PCM_MAX : PCM_MIN);
                    else
                        offer('0);
                end
            end
        endcase
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_request)
            begin
                stall_left      = RX_HOLD_CYCLES;
                rx_hold_request = 1'b0;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (!quiet_traffic && $urandom_range(0, 7) == 0)
            begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 400)
                                                          : $urandom_range(1, 5);
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_sample(sample_out);
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("audio_fir_filter_201_tap regression: fail");
        $finish;
    end

    initial
    begin
        int phase;
        int phase_len;
        int phase_start;
        in_valid        = 1'b0;
        sample_in       = '0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = 1'b0;
        rst_n           = 1'b0;
        words_sent      = 0;
        enable_writes   = 0;
        quiet_traffic   = 1'b1;
        rx_hold_request = 1'b0;
        sb              = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        offer(PCM_MAX);
        offer(PCM_MIN);
        offer('0);
        offer(-16'sd1);
        offer(16'sd1);
        offer(pcm_t'(16'h5a5a));

        set_filter(MODE_FILTER);
        offer(PCM_MAX);
        offer('0);
        offer('0);
        offer(PCM_MIN);
        offer('0);
        offer(16'sd1);
        offer(-16'sd1);
        repeat (5) offer(PCM_MAX);
        repeat (5) offer(PCM_MIN);

        phase = 0;
        while (words_sent < TARGET_WORDS)
        begin
            quiet_traffic = (phase % 4 == 3);
            set_filter((phase % 3 == 1) ? MODE_BYPASS : MODE_FILTER);
            if (phase == 2)
                rx_hold_request = 1'b1;
            phase_len   = $urandom_range(60, 250);
            phase_start = words_sent;
            while (words_sent - phase_start < phase_len)
                random_segment();
            phase++;
        end

        idle_sender(1);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d words: %0d filtered, %0d bypassed, %0d clipped at full scale.",
                 words_sent, sb.filtered, sb.bypassed, sb.clipped);
        $display("Compared %0d outputs over %0d enable writes; %0d mismatches.",
                 sb.checked, enable_writes, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("audio_fir_filter_201_tap regression: pass");
        else
            $display("audio_fir_filter_201_tap regression: fail");
        $finish;
    end

endmodule
